// ===== rtl/mnrq_pkg.sv =====
// Shared types and constants of the MIDI note record quantiser.
package mnrq_pkg;

  localparam int unsigned EW = 27;   // width of the row period 10*rate*speed
  localparam int unsigned SW = 37;   // width of a + b*dr
  localparam int unsigned FB = 11;   // quotient bits of the fractional division
  localparam int unsigned RW = 9;    // width of a row count
  localparam int unsigned QB = 64;   // bits of the frame distance

  typedef enum logic [2:0] {
    CFG_FRAME_RATE    = 3'd0,
    CFG_VEL_TO_VOL    = 3'd1,
    CFG_ARMED_CHANNEL = 3'd2,
    CFG_CHANNEL_COUNT = 3'd3,
    CFG_PATTERN_COUNT = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [17:0] frame_rate;
    logic        vel_to_vol;
    logic [5:0]  armed_channel;
    logic [6:0]  channel_count;
    logic [8:0]  pattern_count;
  } cfg_t;

  typedef struct packed {
    logic          wv;
    logic          fb;
    logic [7:0]    fb_row;
    logic [7:0]    pat;
    logic [5:0]    chan;
    logic [6:0]    note;
    logic [6:0]    vol;
    logic          vv;
    logic [7:0]    row;
    logic [RW-1:0] rows;
    logic [9:0]    b;
    logic [EW-1:0] a;
    logic [EW-1:0] e;
    logic          neg;
  } side_t;

endpackage

// ===== rtl/mnrq_ifs.sv =====
// Request and result channel interfaces of the MIDI note record quantiser.
interface mnrq_rec_if;
  logic       valid;
  logic       ready;
  logic [6:0] midi_key;
  logic [6:0] key_velocity;
  logic [63:0] event_frame;
  logic [63:0] anchor_frame;
  logic       playing;
  logic [7:0] transport_row;
  logic [4:0] transport_tick;
  logic [4:0] ticks_per_row;
  logic [7:0] tempo_bpm;
  logic [8:0] rows_in_pattern;
  logic [7:0] pattern_number;

  modport source (
    output valid, midi_key, key_velocity, event_frame, anchor_frame, playing,
           transport_row, transport_tick, ticks_per_row, tempo_bpm,
           rows_in_pattern, pattern_number,
    input  ready
  );
  modport sink (
    input  valid, midi_key, key_velocity, event_frame, anchor_frame, playing,
           transport_row, transport_tick, ticks_per_row, tempo_bpm,
           rows_in_pattern, pattern_number,
    output ready
  );
endinterface

interface mnrq_cell_if;
  logic       valid;
  logic       ready;
  logic       write_valid;
  logic [7:0] target_pattern;
  logic [7:0] target_row;
  logic [5:0] target_channel;
  logic [6:0] cell_note;
  logic [6:0] cell_volume;
  logic       volume_valid;

  modport source (
    output valid, write_valid, target_pattern, target_row, target_channel,
           cell_note, cell_volume, volume_valid,
    input  ready
  );
  modport sink (
    input  valid, write_valid, target_pattern, target_row, target_channel,
           cell_note, cell_volume, volume_valid,
    output ready
  );
endinterface

// ===== rtl/mnrq_front.sv =====
// Entry stage: clamps, note, volume, frame distance and row period.
module mnrq_front #(
  parameter int unsigned MAX_NOTE = 96,
  parameter int unsigned MAX_ROWS = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  mnrq_pkg::cfg_t       cfg_i,
  mnrq_rec_if.sink             rec,
  output logic                 valid_o,
  output mnrq_pkg::side_t      side_o,
  output logic [63:0]          mag_o
);

  mnrq_pkg::side_t side_d, side_q;
  logic [63:0] mag_d, mag_q, span;
  logic        valid_q;
  logic [8:0]  rows_sat, pc;
  logic [6:0]  cc, nt;
  logic [12:0] y;
  logic [20:0] prod;
  logic [6:0]  q0, q;
  logic [13:0] chk;
  logic [22:0] rs, rt;

  assign rec.ready = en_i;

  always_comb begin
    rows_sat = (32'(rec.rows_in_pattern) > 32'(MAX_ROWS)) ? 9'(MAX_ROWS)
                                                          : rec.rows_in_pattern;
    pc = (cfg_i.pattern_count == 9'd0) ? 9'd1 : cfg_i.pattern_count;
    cc = (cfg_i.channel_count == 7'd0) ? 7'd1 : cfg_i.channel_count;
    nt = (rec.midi_key < 7'd12) ? 7'd1 : rec.midi_key - 7'd11;
    if (nt > 7'(MAX_NOTE)) begin
      nt = 7'(MAX_NOTE);
    end
    y    = {rec.key_velocity, 6'h3f};
    prod = 21'(y) * 21'd129;
    q0   = prod[20:14];
    chk  = 14'(y) - 14'(q0) * 14'd127;
    q    = (chk >= 14'd127) ? q0 + 7'd1 : q0;
    if (q > 7'd64) begin
      q = 7'd64;
    end
    rs   = 23'(cfg_i.frame_rate) * 23'(rec.ticks_per_row);
    rt   = 23'(cfg_i.frame_rate) * 23'(rec.transport_tick);
    span = rec.event_frame - rec.anchor_frame;

    side_d.wv     = rec.playing && (rows_sat != 9'd0);
    side_d.fb     = (rec.ticks_per_row == 5'd0) || (rec.tempo_bpm == 8'd0) ||
                    (cfg_i.frame_rate == 18'd0);
    side_d.fb_row = ({1'b0, rec.transport_row} < rows_sat) ? rec.transport_row
                                                             : 8'(rows_sat - 9'd1);
    side_d.pat    = ({1'b0, rec.pattern_number} > pc - 9'd1) ? 8'(pc - 9'd1)
                                                              : rec.pattern_number;
    side_d.chan   = ({1'b0, cfg_i.armed_channel} > cc - 7'd1) ? 6'(cc - 7'd1)
                                                               : cfg_i.armed_channel;
    side_d.note   = nt;
    side_d.vol    = cfg_i.vel_to_vol ? q : 7'd0;
    side_d.vv     = cfg_i.vel_to_vol;
    side_d.row    = rec.transport_row;
    side_d.rows   = rows_sat;
    side_d.b      = {rec.tempo_bpm, 2'b00};
    side_d.e      = (27'(rs) << 3) + (27'(rs) << 1);
    side_d.a      = (27'(rt) << 3) + (27'(rt) << 1) + (27'(rs) << 2) + 27'(rs);
    side_d.neg    = span[63];
    mag_d         = span[63] ? (~span + 64'd1) : span;
    if (!side_d.wv) begin
      side_d.fb_row = '0;
      side_d.pat    = '0;
      side_d.chan   = '0;
      side_d.note   = '0;
      side_d.vol    = '0;
      side_d.vv     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= rec.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_d;
      mag_q  <= mag_d;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign mag_o   = mag_q;

endmodule

// ===== rtl/mnrq_qdiv.sv =====
// Pipelined restoring divider of the frame distance, quotient kept modulo rows.
module mnrq_qdiv (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  mnrq_pkg::side_t            side_i,
  input  logic [63:0]                mag_i,
  output logic                       valid_o,
  output mnrq_pkg::side_t            side_o,
  output logic [mnrq_pkg::EW-1:0]    rem_o,
  output logic [mnrq_pkg::RW-1:0]    qm_o
);

  localparam int unsigned N = mnrq_pkg::QB;

  logic                    v_s    [N+1];
  mnrq_pkg::side_t         side_s [N+1];
  logic [63:0]             mag_s  [N+1];
  logic [mnrq_pkg::EW-1:0] rem_s  [N+1];
  logic [mnrq_pkg::RW-1:0] qm_s   [N+1];

  assign v_s[0]    = valid_i;
  assign side_s[0] = side_i;
  assign mag_s[0]  = mag_i;
  assign rem_s[0]  = '0;
  assign qm_s[0]   = '0;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [mnrq_pkg::EW:0]   sh;
    logic                    ge;
    logic [mnrq_pkg::EW-1:0] rem_d;
    logic [mnrq_pkg::RW:0]   q2;
    logic [mnrq_pkg::RW-1:0] qm_d;

    always_comb begin
      sh    = {rem_s[k], mag_s[k][63]};
      ge    = sh >= {1'b0, side_s[k].e};
      rem_d = ge ? mnrq_pkg::EW'(sh - {1'b0, side_s[k].e}) : mnrq_pkg::EW'(sh);
      q2    = {qm_s[k], ge};
      qm_d  = (q2 >= {1'b0, side_s[k].rows}) ?
              mnrq_pkg::RW'(q2 - {1'b0, side_s[k].rows}) : mnrq_pkg::RW'(q2);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_s[k+1] <= 1'b0;
      end else if (en_i) begin
        v_s[k+1] <= v_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_s[k+1] <= side_s[k];
        mag_s[k+1]  <= {mag_s[k][62:0], 1'b0};
        rem_s[k+1]  <= rem_d;
        qm_s[k+1]   <= qm_d;
      end
    end
  end

  assign valid_o = v_s[N];
  assign side_o  = side_s[N];
  assign rem_o   = rem_s[N];
  assign qm_o    = qm_s[N];

endmodule

// ===== rtl/mnrq_frac.sv =====
// Sign fix-up, fractional row division and the modulo-rows partial terms.
module mnrq_frac (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  mnrq_pkg::side_t            side_i,
  input  logic [mnrq_pkg::EW-1:0]    rem_i,
  input  logic [mnrq_pkg::RW-1:0]    qm_i,
  output logic                       valid_o,
  output mnrq_pkg::side_t            side_o,
  output logic [mnrq_pkg::RW-1:0]    rowm_o,
  output logic [mnrq_pkg::RW-1:0]    prodm_o,
  output logic [mnrq_pkg::RW-1:0]    fm_o
);

  localparam int unsigned EW = mnrq_pkg::EW;
  localparam int unsigned SW = mnrq_pkg::SW;
  localparam int unsigned RW = mnrq_pkg::RW;
  localparam int unsigned N  = mnrq_pkg::FB;

  logic            fx_v_q;
  mnrq_pkg::side_t fx_side_q;
  logic [EW-1:0]   fx_dr_q, dr_d;
  logic [RW-1:0]   fx_qmod_q, qmod_d;
  logic [RW:0]     qc;

  always_comb begin
    qc     = {1'b0, qm_i};
    dr_d   = rem_i;
    qmod_d = qm_i;
    if (side_i.neg) begin
      if (rem_i != '0) begin
        qc   = qc + 10'd1;
        dr_d = side_i.e - rem_i;
        if (qc == {1'b0, side_i.rows}) begin
          qc = '0;
        end
      end
      qmod_d = (qc == '0) ? '0 : RW'({1'b0, side_i.rows} - qc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fx_v_q <= 1'b0;
    end else if (en_i) begin
      fx_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fx_side_q <= side_i;
      fx_dr_q   <= dr_d;
      fx_qmod_q <= qmod_d;
    end
  end

  logic            v_s    [N+1];
  mnrq_pkg::side_t side_s [N+1];
  logic [SW-1:0]   rem_s  [N+1];
  logic [RW-1:0]   qmod_s [N+1];
  logic [RW-1:0]   fm_s   [N+1];
  logic [RW-1:0]   pm_s   [N+1];
  logic [RW-1:0]   rm_s   [N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_s[0] <= 1'b0;
    end else if (en_i) begin
      v_s[0] <= fx_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_s[0] <= fx_side_q;
      rem_s[0]  <= SW'(fx_side_q.a) + SW'(fx_side_q.b) * SW'(fx_dr_q);
      qmod_s[0] <= fx_qmod_q;
      fm_s[0]   <= '0;
      pm_s[0]   <= '0;
      rm_s[0]   <= '0;
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_stage
    localparam int unsigned K = N - 1 - j;
    logic [SW:0]     sub;
    logic            ge;
    logic [SW-1:0]   rem_d;
    logic [RW:0]     f2, r2, rows1;
    logic [RW+1:0]   p2, rows2;
    logic [N-1:0]    bx, rx;
    logic [RW-1:0]   fm_d, pm_d, rm_d;

    always_comb begin
      sub   = (SW+1)'(side_s[j].e) << K;
      ge    = {1'b0, rem_s[j]} >= sub;
      rem_d = ge ? SW'({1'b0, rem_s[j]} - sub) : rem_s[j];
      rows1 = {1'b0, side_s[j].rows};
      rows2 = {1'b0, side_s[j].rows, 1'b0};
      bx    = N'(side_s[j].b);
      rx    = N'(side_s[j].row);
      f2    = {fm_s[j], ge};
      fm_d  = (f2 >= rows1) ? RW'(f2 - rows1) : RW'(f2);
      r2    = {rm_s[j], rx[K]};
      rm_d  = (r2 >= rows1) ? RW'(r2 - rows1) : RW'(r2);
      p2    = {1'b0, pm_s[j], 1'b0} + (bx[K] ? (RW+2)'(qmod_s[j]) : '0);
      if (p2 >= rows2) begin
        pm_d = RW'(p2 - rows2);
      end else if (p2 >= {1'b0, rows1}) begin
        pm_d = RW'(p2 - {1'b0, rows1});
      end else begin
        pm_d = RW'(p2);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_s[j+1] <= 1'b0;
      end else if (en_i) begin
        v_s[j+1] <= v_s[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_s[j+1] <= side_s[j];
        rem_s[j+1]  <= rem_d;
        qmod_s[j+1] <= qmod_s[j];
        fm_s[j+1]   <= fm_d;
        pm_s[j+1]   <= pm_d;
        rm_s[j+1]   <= rm_d;
      end
    end
  end

  assign valid_o = v_s[N];
  assign side_o  = side_s[N];
  assign rowm_o  = rm_s[N];
  assign prodm_o = pm_s[N];
  assign fm_o    = fm_s[N];

endmodule

// ===== rtl/midi_note_record_quantiser.sv =====
// Top level of the MIDI note record quantiser.
//
// Takes one note-on request with a transport snapshot on rec_i and returns
// one cell result on cell_o for every request, in order. A result with
// write_valid low means no write (transport stopped or empty pattern).
// Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_data_i,
// one register per cycle; the user must write them only while no request
// is in flight; the block itself does not enforce this. A request passes
// through one entry stage, 64 stages of the bit-serial frame distance
// divider (one quotient bit per stage), a sign fix-up stage, a multiply
// stage, 11 stages of the fractional row divider and the output register.
// Throughput: one request per cycle unless held; all stages advance together.
// Reset clears every valid bit and loads the register reset values.
// While the receiver holds cell_o.ready low with a result waiting, the
// whole pipeline holds and rec_i.ready is low; nothing is dropped.
module midi_note_record_quantiser #(
  parameter int unsigned MAX_NOTE = 96,
  parameter int unsigned MAX_ROWS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mnrq_rec_if.sink    rec_i,
  mnrq_cell_if.source cell_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [17:0] cfg_data_i
);

  localparam int unsigned RW = mnrq_pkg::RW;

  mnrq_pkg::cfg_t  cfg_q;
  logic            en;
  logic            f_v, q_v, r_v;
  mnrq_pkg::side_t f_side, q_side, r_side;
  logic [63:0]     f_mag;
  logic [mnrq_pkg::EW-1:0] q_rem;
  logic [RW-1:0]   q_qm, r_rowm, r_prodm, r_fm;
  logic [RW+1:0]   t, rows1, rows2;
  logic [7:0]      row_d;

  logic       out_v_q, wv_q, vv_q;
  logic [7:0] pat_q, row_q;
  logic [5:0] chan_q;
  logic [6:0] note_q, vol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_rate    <= 18'd48000;
      cfg_q.vel_to_vol    <= 1'b0;
      cfg_q.armed_channel <= 6'd0;
      cfg_q.channel_count <= 7'd4;
      cfg_q.pattern_count <= 9'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mnrq_pkg::CFG_FRAME_RATE:    cfg_q.frame_rate    <= cfg_data_i;
        mnrq_pkg::CFG_VEL_TO_VOL:    cfg_q.vel_to_vol    <= cfg_data_i[0];
        mnrq_pkg::CFG_ARMED_CHANNEL: cfg_q.armed_channel <= cfg_data_i[5:0];
        mnrq_pkg::CFG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_data_i[6:0];
        mnrq_pkg::CFG_PATTERN_COUNT: cfg_q.pattern_count <= cfg_data_i[8:0];
        default: begin
        end
      endcase
    end
  end

  assign en = !out_v_q || cell_o.ready;

  mnrq_front #(
    .MAX_NOTE (MAX_NOTE),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cfg_i   (cfg_q),
    .rec     (rec_i),
    .valid_o (f_v),
    .side_o  (f_side),
    .mag_o   (f_mag)
  );

  mnrq_qdiv u_qdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_v),
    .side_i  (f_side),
    .mag_i   (f_mag),
    .valid_o (q_v),
    .side_o  (q_side),
    .rem_o   (q_rem),
    .qm_o    (q_qm)
  );

  mnrq_frac u_frac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (q_v),
    .side_i  (q_side),
    .rem_i   (q_rem),
    .qm_i    (q_qm),
    .valid_o (r_v),
    .side_o  (r_side),
    .rowm_o  (r_rowm),
    .prodm_o (r_prodm),
    .fm_o    (r_fm)
  );

  always_comb begin
    rows1 = (RW+2)'(r_side.rows);
    rows2 = {1'b0, r_side.rows, 1'b0};
    t     = (RW+2)'(r_rowm) + (RW+2)'(r_prodm) + (RW+2)'(r_fm);
    if (t >= rows2) begin
      t = t - rows2;
    end else if (t >= rows1) begin
      t = t - rows1;
    end
    if (!r_side.wv) begin
      row_d = '0;
    end else if (r_side.fb) begin
      row_d = r_side.fb_row;
    end else begin
      row_d = t[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= r_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      wv_q   <= r_side.wv;
      pat_q  <= r_side.pat;
      row_q  <= row_d;
      chan_q <= r_side.chan;
      note_q <= r_side.note;
      vol_q  <= r_side.vol;
      vv_q   <= r_side.vv;
    end
  end

  assign cell_o.valid          = out_v_q;
  assign cell_o.write_valid    = wv_q;
  assign cell_o.target_pattern = pat_q;
  assign cell_o.target_row     = row_q;
  assign cell_o.target_channel = chan_q;
  assign cell_o.cell_note      = note_q;
  assign cell_o.cell_volume    = vol_q;
  assign cell_o.volume_valid   = vv_q;

endmodule

// ===== rtl/mnrq_checker.sv =====
// Port-level assertions of the MIDI note record quantiser and their binding.
module mnrq_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       valid_i,
  input logic       ready_i,
  input logic       write_valid_i,
  input logic [7:0] target_pattern_i,
  input logic [7:0] target_row_i,
  input logic [5:0] target_channel_i,
  input logic [6:0] cell_note_i,
  input logic [6:0] cell_volume_i,
  input logic       volume_valid_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(target_row_i) &&
    $stable(cell_note_i) && $stable(write_valid_i))
    else $error("result changed while stalled");

  a_nowrite_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !write_valid_i |-> target_pattern_i == 8'd0 &&
    target_row_i == 8'd0 && target_channel_i == 6'd0 && cell_note_i == 7'd0 &&
    cell_volume_i == 7'd0 && !volume_valid_i)
    else $error("no-write result carries nonzero fields");

  a_note_vol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && write_valid_i |-> cell_note_i != 7'd0 && cell_volume_i <= 7'd64)
    else $error("note or volume out of range");

  a_vol_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !volume_valid_i |-> cell_volume_i == 7'd0)
    else $error("volume set while disabled");

endmodule

bind midi_note_record_quantiser mnrq_checker u_mnrq_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .valid_i          (cell_o.valid),
  .ready_i          (cell_o.ready),
  .write_valid_i    (cell_o.write_valid),
  .target_pattern_i (cell_o.target_pattern),
  .target_row_i     (cell_o.target_row),
  .target_channel_i (cell_o.target_channel),
  .cell_note_i      (cell_o.cell_note),
  .cell_volume_i    (cell_o.cell_volume),
  .volume_valid_i   (cell_o.volume_valid)
);

// ===== dv/tb_top.sv =====
// Testbench of the MIDI note record quantiser: random and directed requests, scoreboard check.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned NOTE_MAX  = 96;
  localparam int unsigned ROWS_MAX  = 256;
  localparam int unsigned LATENCY   = 79;
  localparam int unsigned IDLE_LIMIT = 4000;

  typedef struct packed {
    logic [6:0]  key;
    logic [6:0]  vel;
    logic [63:0] ev;
    logic [63:0] anchor;
    logic        playing;
    logic [7:0]  row;
    logic [4:0]  tick;
    logic [4:0]  speed;
    logic [7:0]  bpm;
    logic [8:0]  rows;
    logic [7:0]  pat;
  } note_req_t;

  typedef struct packed {
    logic       write_valid;
    logic [7:0] pattern;
    logic [7:0] row;
    logic [5:0] channel;
    logic [6:0] note;
    logic [6:0] volume;
    logic       volume_valid;
  } cell_t;

  class cell_scoreboard;
    cell_t pending[$];
    int    errors;
    logic [17:0] rate;
    logic        vel_to_vol;
    logic [5:0]  armed;
    logic [6:0]  chan_count;
    logic [8:0]  pat_count;

    function new();
      errors = 0;
      rate = 18'd48000;
      vel_to_vol = 1'b0;
      armed = 6'd0;
      chan_count = 7'd4;
      pat_count = 9'd1;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      errors++;
    endtask

    function logic [7:0] quantise_row(note_req_t r, int unsigned rows);
      logic signed [99:0] s_rate, s_tick, s_speed, s_bpm, delta, num, den, q, m, s_rows;
      logic signed [99:0] s_row;
      if (r.speed == 0 || r.bpm == 0 || rate == 0)
        return (r.row < rows) ? r.row : 8'(rows - 1);
      s_rate = rate;
      s_tick = r.tick;
      s_speed = r.speed;
      s_bpm = r.bpm;
      s_rows = rows;
      s_row = r.row;
      delta = $signed(r.ev - r.anchor);
      num = 10 * s_rate * s_tick + 4 * s_bpm * delta + 5 * s_rate * s_speed;
      den = 10 * s_rate * s_speed;
      q = num / den;
      if (num < 0 && (num % den) != 0)
        q = q - 1;
      m = (q + s_row) % s_rows;
      if (m < 0)
        m = m + s_rows;
      return m[7:0];
    endfunction

    function void note_request(note_req_t r);
      cell_t c;
      int unsigned rows, pc, cc, note;
      c = '0;
      rows = (r.rows > ROWS_MAX) ? ROWS_MAX : r.rows;
      if (r.playing && rows != 0) begin
        pc = (pat_count == 0) ? 1 : pat_count;
        cc = (chan_count == 0) ? 1 : chan_count;
        note = (r.key < 12) ? 1 : r.key - 11;
        if (note > NOTE_MAX)
          note = NOTE_MAX;
        c.write_valid = 1'b1;
        c.pattern = (r.pat > pc - 1) ? 8'(pc - 1) : r.pat;
        c.row = quantise_row(r, rows);
        c.channel = (armed > cc - 1) ? 6'(cc - 1) : armed;
        c.note = 7'(note);
        if (vel_to_vol)
          c.volume = ((128 * r.vel + 127) / 254 > 64) ? 7'd64 : 7'((128 * r.vel + 127) / 254);
        c.volume_valid = vel_to_vol;
      end
      pending.push_back(c);
    endfunction

    task check_cell(cell_t got);
      cell_t want;
      if (pending.size() == 0) begin
        report("unexpected result", 0, 0);
        return;
      end
      want = pending.pop_front();
      if (got.write_valid !== want.write_valid)
        report("write_valid", got.write_valid, want.write_valid);
      if (got.pattern !== want.pattern)
        report("target_pattern", got.pattern, want.pattern);
      if (got.row !== want.row)
        report("target_row", got.row, want.row);
      if (got.channel !== want.channel)
        report("target_channel", got.channel, want.channel);
      if (got.note !== want.note)
        report("cell_note", got.note, want.note);
      if (got.volume !== want.volume)
        report("cell_volume", got.volume, want.volume);
      if (got.volume_valid !== want.volume_valid)
        report("volume_valid", got.volume_valid, want.volume_valid);
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [17:0] cfg_data_i;
  bit          steady;
  int unsigned idle_cycles;

  mnrq_rec_if  rec ();
  mnrq_cell_if cell_ch ();

  cell_scoreboard board;

  midi_note_record_quantiser dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rec_i     (rec),
    .cell_o    (cell_ch),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function int unsigned gap_len();
    if (steady)
      return 0;
    if ($urandom_range(0, 9) < 6)
      return 0;
    if ($urandom_range(0, 9) < 8)
      return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_ch.ready <= 1'b0;
    end else begin
      cell_ch.ready <= (gap_len() == 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cell_ch.valid && cell_ch.ready) begin
        board.check_cell({cell_ch.write_valid, cell_ch.target_pattern,
                          cell_ch.target_row, cell_ch.target_channel,
                          cell_ch.cell_note, cell_ch.cell_volume,
                          cell_ch.volume_valid});
      end
      if ((cell_ch.valid && cell_ch.ready) || (rec.valid && rec.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task write_reg(mnrq_pkg::cfg_idx_e idx, logic [17:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    case (idx)
      mnrq_pkg::CFG_FRAME_RATE:    board.rate = value;
      mnrq_pkg::CFG_VEL_TO_VOL:    board.vel_to_vol = value[0];
      mnrq_pkg::CFG_ARMED_CHANNEL: board.armed = value[5:0];
      mnrq_pkg::CFG_CHANNEL_COUNT: board.chan_count = value[6:0];
      mnrq_pkg::CFG_PATTERN_COUNT: board.pat_count = value[8:0];
      default: ;
    endcase
  endtask

  task set_config(logic [17:0] rate, logic vv, logic [5:0] arm, logic [6:0] cc,
                  logic [8:0] pc);
    write_reg(mnrq_pkg::CFG_FRAME_RATE, rate);
    write_reg(mnrq_pkg::CFG_VEL_TO_VOL, 18'(vv));
    write_reg(mnrq_pkg::CFG_ARMED_CHANNEL, 18'(arm));
    write_reg(mnrq_pkg::CFG_CHANNEL_COUNT, 18'(cc));
    write_reg(mnrq_pkg::CFG_PATTERN_COUNT, 18'(pc));
    cfg_we_i <= 1'b0;
  endtask

  task drain();
    while (board.pending.size() != 0)
      @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task send_request(note_req_t r);
    int unsigned n;
    n = gap_len();
    if (n != 0) begin
      rec.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    rec.valid <= 1'b1;
    rec.midi_key <= r.key;
    rec.key_velocity <= r.vel;
    rec.event_frame <= r.ev;
    rec.anchor_frame <= r.anchor;
    rec.playing <= r.playing;
    rec.transport_row <= r.row;
    rec.transport_tick <= r.tick;
    rec.ticks_per_row <= r.speed;
    rec.tempo_bpm <= r.bpm;
    rec.rows_in_pattern <= r.rows;
    rec.pattern_number <= r.pat;
    do
      @(posedge clk_i);
    while (!(rec.valid && rec.ready));
    board.note_request(r);
  endtask

  task end_burst();
    rec.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function note_req_t random_request();
    note_req_t r;
    int unsigned k;
    r.key = 7'($urandom);
    r.vel = 7'($urandom);
    r.anchor = {$urandom, $urandom};
    k = $urandom_range(0, 9);
    if (k < 6)
      r.ev = r.anchor + 64'($signed($urandom_range(0, 400000)) - 200000);
    else if (k < 8)
      r.ev = r.anchor + {{32{$urandom_range(0, 1) == 1}}, $urandom};
    else
      r.ev = {$urandom, $urandom};
    r.playing = ($urandom_range(0, 9) != 0);
    r.row = 8'($urandom);
    r.tick = 5'($urandom);
    r.speed = ($urandom_range(0, 9) == 0) ? 5'd0 : 5'($urandom_range(1, 31));
    r.bpm = ($urandom_range(0, 19) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
    k = $urandom_range(0, 19);
    r.rows = (k == 0) ? 9'd0 : (k < 4) ? 9'd256 : 9'($urandom_range(1, 256));
    r.pat = 8'($urandom);
    return r;
  endfunction

  task random_phase(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 100 == 0)
        steady = ($urandom_range(0, 3) == 0);
      send_request(random_request());
    end
    steady = 1'b0;
    end_burst();
    drain();
  endtask

  task directed_phase();
    note_req_t b, r;
    b = '0;
    b.key = 7'd60;
    b.vel = 7'd100;
    b.ev = 64'd1000;
    b.anchor = 64'd0;
    b.playing = 1'b1;
    b.row = 8'd3;
    b.tick = 5'd2;
    b.speed = 5'd6;
    b.bpm = 8'd125;
    b.rows = 9'd64;
    b.pat = 8'd7;
    send_request(b);
    r = b; r.key = 7'd0; r.vel = 7'd0; send_request(r);
    r = b; r.key = 7'd11; r.vel = 7'd1; send_request(r);
    r = b; r.key = 7'd12; r.vel = 7'd127; send_request(r);
    r = b; r.key = 7'd107; r.vel = 7'd63; send_request(r);
    r = b; r.key = 7'd127; r.vel = 7'd64; send_request(r);
    r = b; r.playing = 1'b0; send_request(r);
    r = b; r.rows = 9'd0; send_request(r);
    r = b; r.rows = 9'd256; r.row = 8'd255; send_request(r);
    r = b; r.rows = 9'd1; send_request(r);
    r = b; r.speed = 5'd0; r.row = 8'd200; send_request(r);
    r = b; r.bpm = 8'd0; r.row = 8'd10; send_request(r);
    r = b; r.ev = 64'd0; r.anchor = 64'h8000_0000_0000_0000; send_request(r);
    r = b; r.ev = 64'h7FFF_FFFF_FFFF_FFFF; r.anchor = 64'd0; send_request(r);
    r = b; r.ev = '1; r.anchor = 64'd0; send_request(r);
    r = b; r.ev = 64'd0; r.anchor = '1; send_request(r);
    r = b; r.ev = '1; r.anchor = '1; send_request(r);
    r = b; r.tick = 5'd31; r.speed = 5'd31; r.bpm = 8'd255; r.row = 8'd255;
    r.pat = 8'd255; send_request(r);
    r = b; r.ev = 64'd0; r.anchor = 64'd5000; r.row = 8'd0; send_request(r);
    r = b; r.ev = 64'd0; r.anchor = 64'd960; r.tick = 5'd0; r.row = 8'd0; send_request(r);
    end_burst();
    drain();
  endtask

  initial begin
    board = new();
    steady = 1'b0;
    idle_cycles = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = mnrq_pkg::CFG_FRAME_RATE;
    cfg_data_i = '0;
    rec.valid = 1'b0;
    rec.midi_key = '0;
    rec.key_velocity = '0;
    rec.event_frame = '0;
    rec.anchor_frame = '0;
    rec.playing = 1'b0;
    rec.transport_row = '0;
    rec.transport_tick = '0;
    rec.ticks_per_row = '0;
    rec.tempo_bpm = '0;
    rec.rows_in_pattern = '0;
    rec.pattern_number = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    random_phase(200);
    set_config(18'd44100, 1'b1, 6'd5, 7'd3, 9'd17);
    directed_phase();
    random_phase(250);
    set_config(18'd0, 1'b1, 6'd2, 7'd64, 9'd256);
    random_phase(200);
    set_config(18'd192000, 1'b1, 6'd63, 7'd64, 9'd256);
    random_phase(250);
    set_config(18'd1, 1'b0, 6'd63, 7'd0, 9'd0);
    random_phase(250);
    set_config(18'd48000, 1'b1, 6'd40, 7'd100, 9'd3);
    random_phase(280);

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== midi_note_record_quantiser.f =====
rtl/mnrq_pkg.sv
rtl/mnrq_ifs.sv
rtl/mnrq_front.sv
rtl/mnrq_qdiv.sv
rtl/mnrq_frac.sv
rtl/midi_note_record_quantiser.sv
rtl/mnrq_checker.sv
dv/tb_top.sv
